// ===== design/esd_pkg.sv =====
// Shared types, character codes and status codes for the escape sequence decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package esd_pkg;

   // Character codes
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // Status reported on the transaction that closes a string
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_BADHEX  = 2'd2,
      ST_CUT     = 2'd3
   } esd_status_type;

   // One raw input byte
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_last;
   } esd_item_type;

   // One decoded result
   typedef struct packed {
      logic [7:0]     out_byte;
      logic           byte_valid;
      logic           string_end;
      esd_status_type status;
   } esd_result_type;

   // Hex digit value: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] res;
      res = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         res = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         res = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         res = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end
      return res;
   endfunction

endpackage

// ===== design/esd_in_stage.sv =====
// Input register stage of the escape sequence decoder.
// Depends on esd_pkg for the item type.
`timescale 1ns / 1ps

module esd_in_stage
   import esd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  esd_item_type req_item,
   output logic         item_valid,
   input  logic         item_take,
   output esd_item_type item
);

   logic         valid_ff, valid_in;
   esd_item_type item_ff;

   // Accept when empty or when the held transaction leaves this cycle
   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/esd_decode.sv =====
// Decode state and result register of the escape sequence decoder.
// Depends on esd_pkg for types, character codes and hex_value.
`timescale 1ns / 1ps

module esd_decode
   import esd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   output logic           item_take,
   input  esd_item_type   item,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output esd_result_type result
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   mode_type       mode_ff, mode_in;
   logic [3:0]     nibble_ff, nibble_in;
   esd_status_type error_ff, error_in;
   logic           rsp_valid_ff, rsp_valid_in;
   esd_result_type result_ff, step_result;
   logic           emit;
   logic [4:0]     hex;
   logic [7:0]     c;
   logic           last;

   assign c    = item.in_byte;
   assign last = item.string_last;
   assign hex  = hex_value(c);

   // Take the held transaction when the result slot is free or draining
   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   // Decode one byte against the current mode
   always_comb begin
      mode_in     = mode_ff;
      nibble_in   = nibble_ff;
      error_in    = error_ff;
      emit        = 1'b0;
      step_result = '{out_byte: 8'd0, byte_valid: 1'b0, string_end: last, status: ST_OK};
      case (mode_ff)
         MODE_ESC: begin
            if (c == CH_N) begin
               mode_in                = MODE_NORMAL;
               emit                   = 1'b1;
               step_result.out_byte   = CH_NEWLINE;
               step_result.byte_valid = 1'b1;
            end else if (c == CH_X) begin
               if (last) begin
                  emit               = 1'b1;
                  step_result.status = ST_CUT;
               end else begin
                  mode_in = MODE_HEX1;
               end
            end else if (last) begin
               emit               = 1'b1;
               step_result.status = ST_UNKNOWN;
            end else begin
               mode_in  = MODE_DROP;
               error_in = ST_UNKNOWN;
            end
         end
         MODE_HEX1: begin
            if (last) begin
               emit               = 1'b1;
               step_result.status = ST_CUT;
            end else if (!hex[4]) begin
               mode_in  = MODE_DROP;
               error_in = ST_BADHEX;
            end else begin
               nibble_in = hex[3:0];
               mode_in   = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            if (!hex[4]) begin
               if (last) begin
                  emit               = 1'b1;
                  step_result.status = ST_BADHEX;
               end else begin
                  mode_in  = MODE_DROP;
                  error_in = ST_BADHEX;
               end
            end else begin
               mode_in                = MODE_NORMAL;
               emit                   = 1'b1;
               step_result.out_byte   = {nibble_ff, hex[3:0]};
               step_result.byte_valid = 1'b1;
            end
         end
         MODE_DROP: begin
            if (last) begin
               emit               = 1'b1;
               step_result.status = error_ff;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (c == CH_BACKSLASH) begin
               if (last) begin
                  emit               = 1'b1;
                  step_result.status = ST_CUT;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else begin
               emit                   = 1'b1;
               step_result.out_byte   = c;
               step_result.byte_valid = 1'b1;
            end
         end
      endcase
      // Return to reset values after every string end
      if (last) begin
         mode_in   = MODE_NORMAL;
         nibble_in = 4'd0;
         error_in  = ST_OK;
      end
   end

   // Result slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (item_take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Hold decode state and result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         nibble_ff    <= 4'd0;
         error_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            mode_ff   <= mode_in;
            nibble_ff <= nibble_in;
            error_ff  <= error_in;
         end
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// ===== design/escape_sequence_decoder_core.sv =====
// Top level of the escape sequence decoder: input stage plus decode stage.
// Depends on esd_pkg, esd_in_stage and esd_decode.
`timescale 1ns / 1ps

// Escape sequence decoder.
// The req channel takes one raw byte per transaction, with req_string_last
// set on the final byte of each string. The rsp channel returns zero or one
// decoded result per input byte: plain bytes pass through, backslash-n gives
// a newline, backslash-x with two hex digits gives one byte. An error makes
// the block drop bytes until the string end, where one result with
// rsp_byte_valid low reports the status; the closing result of every string
// carries rsp_string_end.
// Path: an accepted byte is loaded into the input register, and the decode
// logic fills the result register from it once the result slot is free.
// Throughput: one byte per cycle while results drain; the mode, nibble and
// error registers update in the same cycle that a byte is decoded.
// Reset: synchronous, active high; empties both stages and returns the
// decode state to normal mode.
// Stall: while rsp_ready is low the result is held; one more byte waits in
// the input register, then req_ready drops until the result is taken.
module escape_sequence_decoder_core
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_end,
   output logic [1:0] rsp_status
);

   esd_item_type   req_item;
   esd_item_type   item;
   logic           item_valid;
   logic           item_take;
   esd_result_type result;

   assign req_item = '{in_byte: req_in_byte, string_last: req_string_last};

   esd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   esd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result     (result)
   );

   assign rsp_out_byte   = result.out_byte;
   assign rsp_byte_valid = result.byte_valid;
   assign rsp_string_end = result.string_end;
   assign rsp_status     = result.status;

endmodule

// ===== design/esd_checker.sv =====
// Port-level checks for the escape sequence decoder, bound to the top level.
// Depends on esd_pkg for status codes.
`timescale 1ns / 1ps

module esd_checker
   import esd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_string_end,
   input logic [1:0] rsp_status
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_string_end))
      else $error("stalled result changed");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result without a byte only closes a string
   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_string_end && rsp_out_byte == 8'd0)
      else $error("empty result not at string end");

   // An error status never comes with a decoded byte
   a_error_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_byte_valid && rsp_string_end)
      else $error("error status with decoded byte");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_string_end (rsp_string_end),
   .rsp_status     (rsp_status)
);
